// ===== hdl/buffer_pool_lru_directory_macros.svh =====
// Assertion macros shared by the buffer pool directory RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BUFFER_POOL_LRU_DIRECTORY_MACROS_SVH
`define BUFFER_POOL_LRU_DIRECTORY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check that is switched off while reset is high.
`define BPLRU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define BPLRU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPLRU_ASSERT(label, clk, rst, prop, msg)
`define BPLRU_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/bplru_pkg.sv =====
package bplru_pkg;

   // Fixed field widths of the transaction ports.
   localparam int BLK_W  = 16;
   localparam int SLOT_W = 5;
   localparam int WB_W   = 13;
   localparam int AGE_W  = 8;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   // Operation codes.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_DIRTY  = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OOB  = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } fsm_state_type;

   // One response as handed from the sequencer to the output register.
   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic              wb_valid;
      logic [WB_W-1:0]   wb_block;
   } rsp_type;

endpackage

// ===== hdl/bplru_ram.sv =====
module bplru_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bplru_ctrl.sv =====
`include "buffer_pool_lru_directory_macros.svh"

module bplru_ctrl #(
   parameter int NUM_SLOTS = 32,
   parameter int NUM_DISK_BLOCKS = 8192,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
   localparam int TAG_W = (NUM_DISK_BLOCKS > 2) ? $clog2(NUM_DISK_BLOCKS) : 1,
   localparam int ENT_W = TAG_W + 1 + bplru_pkg::AGE_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [1:0]                       req_opcode,
   input  logic [bplru_pkg::BLK_W-1:0]      req_block_num,
   output logic                             busy,
   output logic                             mem_rd_en,
   output logic [IDX_W-1:0]                 mem_rd_addr,
   input  logic [ENT_W-1:0]                 mem_rd_data,
   output logic                             mem_wr_en,
   output logic [IDX_W-1:0]                 mem_wr_addr,
   output logic [ENT_W-1:0]                 mem_wr_data,
   output logic [IDX_W-1:0]                 vld_rd_idx,
   input  logic                             vld_bit,
   output logic                             vld_set,
   output logic [IDX_W-1:0]                 vld_set_idx,
   output logic                             rsp_load,
   output bplru_pkg::rsp_type               rsp
);

   localparam int BlkW  = bplru_pkg::BLK_W;
   localparam int AgeW  = bplru_pkg::AGE_W;
   localparam int SlotW = bplru_pkg::SLOT_W;
   localparam int WbW   = bplru_pkg::WB_W;
   localparam logic [BlkW:0]    BlkLimit = (BlkW + 1)'(NUM_DISK_BLOCKS);
   localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(NUM_SLOTS - 1);

   bplru_pkg::fsm_state_type state_ff, state_in;

   logic [1:0]       op_ff, op_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             p_vld_ff, p_vld_in;
   logic [IDX_W-1:0] p_idx_ff, p_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] cap_idx_ff, cap_idx_in;
   logic [TAG_W-1:0] cap_tag_ff, cap_tag_in;
   logic             cap_dirty_ff, cap_dirty_in;
   logic [AgeW-1:0]  cap_age_ff, cap_age_in;

   logic             req_bad_op;
   logic             req_oob;
   logic             launch;
   logic [TAG_W-1:0] e_tag;
   logic             e_dirty;
   logic [AgeW-1:0]  e_age;
   logic [AgeW-1:0]  e_aged;
   logic [IDX_W-1:0] alloc_idx;

   // Decode of the incoming transaction.
   assign req_bad_op = (req_opcode != bplru_pkg::OP_LOOKUP) &&
                       (req_opcode != bplru_pkg::OP_ALLOC) &&
                       (req_opcode != bplru_pkg::OP_DIRTY);
   assign req_oob    = {1'b0, req_block_num} >= BlkLimit;
   assign launch     = start && (state_ff == bplru_pkg::S_IDLE) && !req_bad_op && !req_oob;

   // Fields of the entry that came back from the directory memory.
   assign e_tag   = mem_rd_data[ENT_W-1 -: TAG_W];
   assign e_dirty = mem_rd_data[AgeW];
   assign e_age   = mem_rd_data[AgeW-1:0];
   assign e_aged  = (e_age == bplru_pkg::AGE_MAX) ? e_age : AgeW'(e_age + 1'b1);

   // A free slot wins over the oldest one.
   assign alloc_idx = found_ff ? free_idx_ff : cap_idx_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bplru_pkg::S_IDLE: begin
            if (launch) begin
               state_in = bplru_pkg::S_SCAN;
            end
         end
         bplru_pkg::S_SCAN: begin
            if (rd_idx_ff == LastIdx) begin
               state_in = bplru_pkg::S_DRAIN;
            end
         end
         bplru_pkg::S_DRAIN: begin
            state_in = bplru_pkg::S_COMMIT;
         end
         bplru_pkg::S_COMMIT: begin
            state_in = bplru_pkg::S_IDLE;
         end
         default: begin
            state_in = bplru_pkg::S_IDLE;
         end
      endcase
   end

   // Scan datapath, memory accesses and response.
   always_comb begin
      op_in        = op_ff;
      tag_in       = tag_ff;
      rd_idx_in    = rd_idx_ff;
      p_vld_in     = 1'b0;
      p_idx_in     = rd_idx_ff;
      found_in     = found_ff;
      free_idx_in  = free_idx_ff;
      cap_idx_in   = cap_idx_ff;
      cap_tag_in   = cap_tag_ff;
      cap_dirty_in = cap_dirty_ff;
      cap_age_in   = cap_age_ff;

      busy         = (state_ff != bplru_pkg::S_IDLE);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = p_idx_ff;
      mem_wr_data  = {e_tag, e_dirty, e_aged};
      vld_rd_idx   = p_idx_ff;
      vld_set      = 1'b0;
      vld_set_idx  = alloc_idx;
      rsp_load     = 1'b0;
      rsp          = '0;

      unique case (state_ff)
         bplru_pkg::S_IDLE: begin
            // Bad opcodes and out-of-range blocks answer at once.
            if (start) begin
               if (req_bad_op) begin
                  rsp_load   = 1'b1;
                  rsp.status = bplru_pkg::STATUS_MISS;
               end else if (req_oob) begin
                  rsp_load   = 1'b1;
                  rsp.status = bplru_pkg::STATUS_OOB;
               end else begin
                  op_in     = req_opcode;
                  tag_in    = req_block_num[TAG_W-1:0];
                  rd_idx_in = '0;
                  found_in  = 1'b0;
               end
            end
         end
         bplru_pkg::S_SCAN: begin
            // Read one slot per cycle.
            mem_rd_en = 1'b1;
            p_vld_in  = 1'b1;
            p_idx_in  = rd_idx_ff;
            rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
         end
         bplru_pkg::S_DRAIN: begin
         end
         bplru_pkg::S_COMMIT: begin
            rsp_load = 1'b1;
            if (op_ff == bplru_pkg::OP_ALLOC) begin
               // Install the new block clean and young.
               mem_wr_en       = 1'b1;
               mem_wr_addr     = alloc_idx;
               mem_wr_data     = {tag_ff, 1'b0, AgeW'(0)};
               vld_set         = 1'b1;
               rsp.status      = bplru_pkg::STATUS_OK;
               rsp.slot        = SlotW'(alloc_idx);
               rsp.wb_valid    = !found_ff && cap_dirty_ff;
               if (!found_ff && cap_dirty_ff) begin
                  rsp.wb_block = WbW'(BlkW'(cap_tag_ff));
               end
            end else if (found_ff) begin
               rsp.status = bplru_pkg::STATUS_OK;
               rsp.slot   = SlotW'(cap_idx_ff);
               if (op_ff == bplru_pkg::OP_DIRTY) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = cap_idx_ff;
                  mem_wr_data = {cap_tag_ff, 1'b1, cap_age_ff};
               end
            end else begin
               rsp.status = bplru_pkg::STATUS_MISS;
            end
         end
         default: begin
         end
      endcase

      // Process the entry read in the previous cycle.
      if (p_vld_ff) begin
         if (op_ff == bplru_pkg::OP_ALLOC) begin
            // Age occupied slots in place.
            if (vld_bit) begin
               mem_wr_en = 1'b1;
            end
            if (!vld_bit && !found_ff) begin
               found_in    = 1'b1;
               free_idx_in = p_idx_ff;
            end
            // Oldest slot, lowest index on a tie.
            if ((p_idx_ff == '0) || (e_aged > cap_age_ff)) begin
               cap_idx_in   = p_idx_ff;
               cap_tag_in   = e_tag;
               cap_dirty_in = e_dirty;
               cap_age_in   = e_aged;
            end
         end else if (vld_bit && (e_tag == tag_ff) && !found_ff) begin
            // First matching slot.
            found_in     = 1'b1;
            cap_idx_in   = p_idx_ff;
            cap_tag_in   = e_tag;
            cap_dirty_in = e_dirty;
            cap_age_in   = e_age;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bplru_pkg::S_IDLE;
         p_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_vld_ff <= p_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      rd_idx_ff    <= rd_idx_in;
      p_idx_ff     <= p_idx_in;
      found_ff     <= found_in;
      free_idx_ff  <= free_idx_in;
      cap_idx_ff   <= cap_idx_in;
      cap_tag_ff   <= cap_tag_in;
      cap_dirty_ff <= cap_dirty_in;
      cap_age_ff   <= cap_age_in;
   end

   // The aging write-back never lands on the slot being read.
   `BPLRU_ASSERT(a_no_rw_clash, clock, reset,
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr),
      "directory read and write hit the same slot")

   // Each response ends the transaction.
   `BPLRU_ASSERT(a_rsp_ends_op, clock, reset,
      rsp_load |=> (state_ff == bplru_pkg::S_IDLE),
      "sequencer still busy after a response")

endmodule

// ===== hdl/buffer_pool_lru_directory.sv =====
// Buffer pool directory with least-recently-allocated replacement.
//
// Command channel: drive req_opcode and req_block_num with start high; the
// transaction is taken at a clock edge where busy is low. Lookup returns the
// slot holding the block, allocate ages every occupied slot and installs the
// block in the lowest free slot or else in the oldest one (reporting a dirty
// victim for write-back), and mark-dirty flags the block's slot.
// Response channel: rsp_strobe is high for exactly one cycle with the status,
// slot and write-back fields of one transaction. The receiver cannot stall.
// Sequence: a scanned operation reads the directory memory one slot per cycle,
// then passes through the drain and commit states before its strobe is shown.
// Out-of-range blocks and unknown opcodes answer on the next cycle. busy
// drops in the cycle that the strobe is shown, so a new command can be taken
// at the edge that ends it. Reset clears every valid bit, which empties the
// pool; tags, dirty bits and ages only matter for valid slots and need no
// clearing.
`include "buffer_pool_lru_directory_macros.svh"

module buffer_pool_lru_directory #(
   parameter int NUM_SLOTS = 32,
   parameter int NUM_DISK_BLOCKS = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [bplru_pkg::BLK_W-1:0]      req_block_num,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [bplru_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                             rsp_writeback_valid,
   output logic [bplru_pkg::WB_W-1:0]       rsp_writeback_block
);

   localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TagW = (NUM_DISK_BLOCKS > 2) ? $clog2(NUM_DISK_BLOCKS) : 1;
   localparam int EntW = TagW + 1 + bplru_pkg::AGE_W;

   logic                 mem_rd_en;
   logic [IdxW-1:0]      mem_rd_addr;
   logic [EntW-1:0]      mem_rd_data;
   logic                 mem_wr_en;
   logic [IdxW-1:0]      mem_wr_addr;
   logic [EntW-1:0]      mem_wr_data;
   logic [IdxW-1:0]      vld_rd_idx;
   logic                 vld_set;
   logic [IdxW-1:0]      vld_set_idx;
   logic                 rsp_load;
   bplru_pkg::rsp_type   rsp;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 rsp_strobe_ff;
   bplru_pkg::rsp_type   rsp_ff;

   // Sequencer that scans the directory.
   bplru_ctrl #(
      .NUM_SLOTS       (NUM_SLOTS),
      .NUM_DISK_BLOCKS (NUM_DISK_BLOCKS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_opcode    (req_opcode),
      .req_block_num (req_block_num),
      .busy          (busy),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .vld_rd_idx    (vld_rd_idx),
      .vld_bit       (valid_ff[vld_rd_idx]),
      .vld_set       (vld_set),
      .vld_set_idx   (vld_set_idx),
      .rsp_load      (rsp_load),
      .rsp           (rsp)
   );

   // Tag, dirty bit and age of every slot.
   bplru_ram #(
      .WIDTH (EntW),
      .DEPTH (NUM_SLOTS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Slot occupancy: set by allocation, never cleared but by reset.
   always_comb begin
      valid_in = valid_ff;
      if (vld_set) begin
         valid_in[vld_set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_load;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_slot            = rsp_ff.slot;
   assign rsp_writeback_valid = rsp_ff.wb_valid;
   assign rsp_writeback_block = rsp_ff.wb_block;

   // Work starts only on an accepted transaction.
   `BPLRU_ASSERT(a_busy_from_start, clock, reset,
      $rose(busy) |-> $past(start),
      "busy rose without a command")

   // Slots are claimed only inside a transaction.
   `BPLRU_ASSERT(a_set_while_busy, clock, reset,
      vld_set |-> busy,
      "slot claimed while idle")

endmodule

// ===== verif/tb_buffer_pool_lru_directory.sv =====
module tb_buffer_pool_lru_directory;
   timeunit 1ns;
   timeprecision 1ps;

   import bplru_pkg::*;

   localparam int NUM_SLOTS       = 32;
   localparam int NUM_DISK_BLOCKS = 8192;
   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 40;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOT_BLOCKS      = 48;
   localparam int SEQUENCES       = 1000;

   // Opcode 3 has no operation behind it.
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_opcode = OP_LOOKUP;
   logic [BLK_W-1:0]    req_block_num = '0;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_writeback_valid;
   logic [WB_W-1:0]     rsp_writeback_block;

   bit                  idle_enabled = 1'b1;
   int unsigned         stall_cycles = 0;
   logic [BLK_W-1:0]    hot_pool [HOT_BLOCKS];

   // Directory shadow and the queue of responses it predicts.
   class directory_scoreboard;
      bit                slot_valid [NUM_SLOTS];
      bit                slot_dirty [NUM_SLOTS];
      logic [WB_W-1:0]   slot_tag   [NUM_SLOTS];
      logic [AGE_W-1:0]  slot_age   [NUM_SLOTS];
      rsp_type           pending_responses [$];
      int unsigned       failures;

      function new();
         failures = 0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_dirty[i] = 1'b0;
            slot_tag[i]   = '0;
            slot_age[i]   = '0;
         end
      endfunction

      // Lowest valid slot holding the block, or NUM_SLOTS when none does.
      function int find_block(logic [BLK_W-1:0] blk);
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && slot_tag[i] == blk[WB_W-1:0]) begin
               return i;
            end
         end
         return NUM_SLOTS;
      endfunction

      // Applies one accepted command to the shadow and queues its response.
      function void note_command(logic [1:0] op, logic [BLK_W-1:0] blk);
         rsp_type expected;
         int      victim;
         expected = '0;
         expected.status = STATUS_OK;
         if (op != OP_LOOKUP && op != OP_ALLOC && op != OP_DIRTY) begin
            expected.status = STATUS_MISS;
         end else if (blk >= NUM_DISK_BLOCKS) begin
            expected.status = STATUS_OOB;
         end else if (op == OP_ALLOC) begin
            // Every occupied slot ages, saturating at the top.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_valid[i] && slot_age[i] != AGE_MAX) begin
                  slot_age[i] = slot_age[i] + 1'b1;
               end
            end
            victim = NUM_SLOTS;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!slot_valid[i] && victim == NUM_SLOTS) begin
                  victim = i;
               end
            end
            // With no free slot, the first slot of greatest age is evicted.
            if (victim == NUM_SLOTS) begin
               victim = 0;
               for (int i = 1; i < NUM_SLOTS; i++) begin
                  if (slot_age[i] > slot_age[victim]) begin
                     victim = i;
                  end
               end
               if (slot_dirty[victim]) begin
                  expected.wb_valid = 1'b1;
                  expected.wb_block = slot_tag[victim];
               end
            end
            slot_valid[victim] = 1'b1;
            slot_dirty[victim] = 1'b0;
            slot_tag[victim]   = blk[WB_W-1:0];
            slot_age[victim]   = '0;
            expected.slot      = victim[SLOT_W-1:0];
         end else begin
            victim = find_block(blk);
            if (victim == NUM_SLOTS) begin
               expected.status = STATUS_MISS;
            end else begin
               if (op == OP_DIRTY) begin
                  slot_dirty[victim] = 1'b1;
               end
               expected.slot = victim[SLOT_W-1:0];
            end
         end
         pending_responses.push_back(expected);
      endfunction

      // Compares one response with the oldest prediction.
      function void check_response(rsp_type actual);
         rsp_type expected;
         if (pending_responses.size() == 0) begin
            $error("response with no command outstanding");
            failures++;
            return;
         end
         expected = pending_responses.pop_front();
         if (actual.status !== expected.status) begin
            $error("status: expected %0d, actual %0d", expected.status, actual.status);
            failures++;
         end
         if (actual.slot !== expected.slot) begin
            $error("slot: expected %0d, actual %0d", expected.slot, actual.slot);
            failures++;
         end
         if (actual.wb_valid !== expected.wb_valid) begin
            $error("writeback_valid: expected %0d, actual %0d",
                   expected.wb_valid, actual.wb_valid);
            failures++;
         end
         if (actual.wb_block !== expected.wb_block) begin
            $error("writeback_block: expected %0d, actual %0d",
                   expected.wb_block, actual.wb_block);
            failures++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_responses.size();
      endfunction
   endclass

   directory_scoreboard sb;

   buffer_pool_lru_directory #(
      .NUM_SLOTS(NUM_SLOTS),
      .NUM_DISK_BLOCKS(NUM_DISK_BLOCKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_block_num(req_block_num),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_slot(rsp_slot),
      .rsp_writeback_valid(rsp_writeback_valid),
      .rsp_writeback_block(rsp_writeback_block)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Monitor both channels and watch for a stalled run.
   always @(posedge clock) begin
      rsp_type actual;
      if (!reset) begin
         if (start && !busy) begin
            sb.note_command(req_opcode, req_block_num);
         end
         if (rsp_strobe) begin
            actual.status   = rsp_status;
            actual.slot     = rsp_slot;
            actual.wb_valid = rsp_writeback_valid;
            actual.wb_block = rsp_writeback_block;
            sb.check_response(actual);
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("buffer_pool_lru_directory regression: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Issues one command after a random gap and holds it until it is taken.
   task automatic send_command(input logic [1:0] op, input logic [BLK_W-1:0] blk);
      int unsigned gap;
      gap = idle_enabled ? $urandom_range(14) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_block_num <= blk;
      do @(posedge clock); while (busy);
   endtask

   // Stops issuing until every outstanding response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic logic [BLK_W-1:0] pick_block();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) begin
         return hot_pool[$urandom_range(HOT_BLOCKS - 1)];
      end else if (r < 88) begin
         return BLK_W'($urandom_range(NUM_DISK_BLOCKS - 1));
      end else if (r < 90) begin
         return ($urandom_range(1) != 0) ? BLK_W'(NUM_DISK_BLOCKS - 1) : '0;
      end
      return BLK_W'($urandom_range(65535, NUM_DISK_BLOCKS));
   endfunction

   function automatic logic [1:0] pick_opcode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 4) begin
         return OP_UNDEFINED;
      end else if (r < 40) begin
         return OP_ALLOC;
      end else if (r < 70) begin
         return OP_LOOKUP;
      end
      return OP_DIRTY;
   endfunction

   initial begin
      logic [BLK_W-1:0] blk;
      sb = new();
      for (int i = 0; i < HOT_BLOCKS; i++) begin
         hot_pool[i] = BLK_W'($urandom_range(NUM_DISK_BLOCKS - 1));
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pool, bounds, unknown opcode, duplicates and dirty marks.
      send_command(OP_LOOKUP, 16'd0);
      send_command(OP_DIRTY, 16'd0);
      send_command(OP_LOOKUP, 16'd8192);
      send_command(OP_ALLOC, 16'd8192);
      send_command(OP_DIRTY, 16'hFFFF);
      send_command(OP_UNDEFINED, 16'd0);
      send_command(OP_UNDEFINED, 16'hFFFF);
      send_command(OP_ALLOC, 16'd0);
      send_command(OP_ALLOC, 16'd8191);
      send_command(OP_ALLOC, 16'd0);
      send_command(OP_LOOKUP, 16'd0);
      send_command(OP_DIRTY, 16'd0);
      send_command(OP_DIRTY, 16'd8191);
      send_command(OP_LOOKUP, 16'd8191);
      send_command(OP_LOOKUP, 16'd5);
      send_command(OP_ALLOC, 16'hFFFF);
      send_command(OP_ALLOC, 16'h1555);
      send_command(OP_DIRTY, 16'h0AAA);
      send_command(OP_LOOKUP, 16'h1555);
      drain_responses();

      // Random: about 30% of sequences allocate, dirty and look up one hot block; the rest send one loose command.
      for (int seq = 0; seq < SEQUENCES; seq++) begin
         if (seq % 50 == 0) begin
            idle_enabled = ($urandom_range(3) != 0);
         end
         if (seq % 250 == 249) begin
            drain_responses();
         end
         if ($urandom_range(49) == 0) begin
            hot_pool[$urandom_range(HOT_BLOCKS - 1)] =
               BLK_W'($urandom_range(NUM_DISK_BLOCKS - 1));
         end
         if ($urandom_range(99) < 30) begin
            blk = hot_pool[$urandom_range(HOT_BLOCKS - 1)];
            send_command(OP_ALLOC, blk);
            send_command(OP_DIRTY, blk);
            send_command(OP_LOOKUP, blk);
         end else begin
            send_command(pick_opcode(), pick_block());
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("buffer_pool_lru_directory regression: pass");
      end else begin
         $display("buffer_pool_lru_directory regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bplru_pkg.sv
hdl/bplru_ram.sv
hdl/bplru_ctrl.sv
hdl/buffer_pool_lru_directory.sv
verif/tb_buffer_pool_lru_directory.sv
